>>> rtl/dlle_pkg.sv
package dlle_pkg;

   localparam int CAPACITY   = 32;
   localparam int DATA_WIDTH = 32;

   // index width holds the null marker, address width only real entries
   localparam int IDX_W  = $clog2(CAPACITY + 1);
   localparam int ADDR_W = $clog2(CAPACITY);

   localparam logic [IDX_W-1:0] NULL_IDX = IDX_W'(CAPACITY);

   typedef logic [IDX_W-1:0]              idx_type;
   typedef logic [ADDR_W-1:0]             addr_type;
   typedef logic signed [DATA_WIDTH-1:0]  data_type;
   typedef logic signed [31:0]            word_type;
   typedef logic [2:0]                    cmd_field_type;
   typedef logic [5:0]                    count_field_type;

   typedef enum logic [2:0] {
      CMD_INS_FRONT = 3'd0,
      CMD_INS_END   = 3'd1,
      CMD_INS_AFTER = 3'd2,
      CMD_DEL_FRONT = 3'd3,
      CMD_DEL_END   = 3'd4,
      CMD_DEL_KEY   = 3'd5,
      CMD_CLEAR     = 3'd6
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

endpackage

>>> rtl/dlle_if.sv
interface dlle_req_if;
   import dlle_pkg::*;

   logic          valid;
   logic          ready;
   cmd_field_type cmd;
   word_type      key;
   word_type      value;

   modport source (output valid, output cmd, output key, output value, input ready);
   modport sink   (input valid, input cmd, input key, input value, output ready);
endinterface

interface dlle_rsp_if;
   import dlle_pkg::*;

   logic            valid;
   logic            ready;
   status_type      status;
   count_field_type element_count;
   logic            is_empty;
   word_type        head_value;
   word_type        tail_value;

   modport source (output valid, output status, output element_count, output is_empty,
                   output head_value, output tail_value, input ready);
   modport sink   (input valid, input status, input element_count, input is_empty,
                   input head_value, input tail_value, output ready);
endinterface

>>> rtl/doubly_linked_list_engine.sv
// channel  | dir | payload                                                  | handshake
// req_if   | in  | cmd, key, value                                          | valid/ready
// rsp_if   | out | status, element_count, is_empty, head_value, tail_value | valid/ready
//
// front, end and clear commands need no walk of the list; insert-after and
// delete-by-key follow one link per cycle through the single read port of
// the node memories.
// reset clears the list registers and the free chain valid bits, no sweep.
// a result waits in the output register while rsp_if.ready is low; the next command
// is taken meanwhile and holds at its result stage until the register frees up.
module doubly_linked_list_engine (
   input  logic         clock,
   input  logic         reset,
   dlle_req_if.sink     req_if,
   dlle_rsp_if.source   rsp_if
);
   import dlle_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_INS_WR,
      S_INS_LINK,
      S_SRCH,
      S_IA_WR,
      S_IA_LINK,
      S_TAIL_CHK,
      S_REP_HEAD,
      S_REP_TAIL,
      S_REP_DONE
   } state_type;

   // node pool and free chain
   data_type data_mem [CAPACITY];
   idx_type  next_mem [CAPACITY];
   idx_type  prev_mem [CAPACITY];
   idx_type  free_mem [CAPACITY];

   state_type       state_ff, state_in;
   cmd_field_type   cmd_ff, cmd_in;
   data_type        key_ff, key_in;
   data_type        value_ff, value_in;
   status_type      status_ff, status_in;
   idx_type         head_ff, head_in;
   idx_type         tail_ff, tail_in;
   idx_type         count_ff, count_in;
   idx_type         free_head_ff, free_head_in;
   logic [CAPACITY-1:0] free_valid_ff, free_valid_in;
   idx_type         n_ff, n_in;
   idx_type         cur_ff, cur_in;
   idx_type         after_ff, after_in;
   word_type        hv_ff, hv_in;

   logic            rsp_valid_ff, rsp_valid_in;
   status_type      rsp_status_ff, rsp_status_in;
   count_field_type rsp_count_ff, rsp_count_in;
   logic            rsp_empty_ff, rsp_empty_in;
   word_type        rsp_head_ff, rsp_head_in;
   word_type        rsp_tail_ff, rsp_tail_in;

   // registered memory read data
   data_type data_rd_ff;
   idx_type  next_rd_ff;
   idx_type  prev_rd_ff;
   idx_type  free_rd_ff;
   logic     free_v_ff;

   addr_type node_raddr;
   logic     data_we, next_we, prev_we, free_we;
   addr_type data_waddr, next_waddr, prev_waddr, free_waddr;
   data_type data_wdata;
   idx_type  next_wdata, prev_wdata;

   logic     do_del_front, do_del_end, do_release;
   idx_type  rel_idx;
   idx_type  free_next;
   logic     key_hit;
   logic     ins_empty;

   assign free_next = free_v_ff ? free_rd_ff : free_head_ff + 1'b1;
   assign key_hit   = (data_rd_ff == key_ff);

   assign req_if.ready         = (state_ff == S_IDLE);
   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.status        = rsp_status_ff;
   assign rsp_if.element_count = rsp_count_ff;
   assign rsp_if.is_empty      = rsp_empty_ff;
   assign rsp_if.head_value    = rsp_head_ff;
   assign rsp_if.tail_value    = rsp_tail_ff;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      value_in      = value_ff;
      status_in     = status_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      free_head_in  = free_head_ff;
      free_valid_in = free_valid_ff;
      n_in          = n_ff;
      cur_in        = cur_ff;
      after_in      = after_ff;
      hv_in         = hv_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_head_in   = rsp_head_ff;
      rsp_tail_in   = rsp_tail_ff;

      node_raddr    = head_ff[ADDR_W-1:0];
      data_we       = 1'b0;
      next_we       = 1'b0;
      prev_we       = 1'b0;
      free_we       = 1'b0;
      data_waddr    = n_ff[ADDR_W-1:0];
      next_waddr    = n_ff[ADDR_W-1:0];
      prev_waddr    = n_ff[ADDR_W-1:0];
      free_waddr    = head_ff[ADDR_W-1:0];
      data_wdata    = value_ff;
      next_wdata    = NULL_IDX;
      prev_wdata    = NULL_IDX;

      do_del_front  = 1'b0;
      do_del_end    = 1'b0;
      do_release    = 1'b0;
      rel_idx       = head_ff;
      ins_empty     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               cmd_in    = req_if.cmd;
               key_in    = data_type'(req_if.key);
               value_in  = data_type'(req_if.value);
               status_in = ST_OK;
               state_in  = S_DECODE;
            end
         end

         // read data here belongs to the head node
         S_DECODE: begin
            state_in = S_REP_HEAD;
            case (cmd_ff)
               CMD_INS_FRONT, CMD_INS_END: begin
                  if (free_head_ff == NULL_IDX) begin
                     status_in = ST_FULL;
                  end else begin
                     n_in         = free_head_ff;
                     free_head_in = free_next;
                     state_in     = S_INS_WR;
                  end
               end
               CMD_INS_AFTER: begin
                  if (head_ff == NULL_IDX) begin
                     status_in = ST_EMPTY;
                  end else begin
                     cur_in   = head_ff;
                     state_in = S_SRCH;
                  end
               end
               CMD_DEL_FRONT: begin
                  if (head_ff == NULL_IDX) status_in = ST_EMPTY;
                  else do_del_front = 1'b1;
               end
               CMD_DEL_END: begin
                  if (tail_ff == NULL_IDX) begin
                     status_in = ST_EMPTY;
                  end else begin
                     node_raddr = tail_ff[ADDR_W-1:0];
                     state_in   = S_TAIL_CHK;
                  end
               end
               CMD_DEL_KEY: begin
                  if (head_ff == NULL_IDX || tail_ff == NULL_IDX) begin
                     status_in = ST_EMPTY;
                  end else if (key_hit) begin
                     do_del_front = 1'b1;
                  end else begin
                     node_raddr = tail_ff[ADDR_W-1:0];
                     state_in   = S_TAIL_CHK;
                  end
               end
               CMD_CLEAR: begin
                  head_in       = NULL_IDX;
                  tail_in       = NULL_IDX;
                  count_in      = '0;
                  free_head_in  = '0;
                  free_valid_in = '0;
               end
               default: ;
            endcase
         end

         // new node written, then the neighbor gets linked unless the list was empty
         S_INS_WR: begin
            data_we = 1'b1;
            next_we = 1'b1;
            prev_we = 1'b1;
            if (cmd_ff == CMD_INS_FRONT) begin
               next_wdata = head_ff;
               prev_wdata = NULL_IDX;
               ins_empty  = (head_ff == NULL_IDX);
            end else begin
               next_wdata = NULL_IDX;
               prev_wdata = tail_ff;
               ins_empty  = (tail_ff == NULL_IDX);
            end
            if (ins_empty) begin
               head_in  = n_ff;
               tail_in  = n_ff;
               count_in = count_ff + 1'b1;
               state_in = S_REP_HEAD;
            end else begin
               state_in = S_INS_LINK;
            end
         end

         S_INS_LINK: begin
            if (cmd_ff == CMD_INS_FRONT) begin
               prev_we    = 1'b1;
               prev_waddr = head_ff[ADDR_W-1:0];
               prev_wdata = n_ff;
               head_in    = n_ff;
            end else begin
               next_we    = 1'b1;
               next_waddr = tail_ff[ADDR_W-1:0];
               next_wdata = n_ff;
               tail_in    = n_ff;
            end
            count_in = count_ff + 1'b1;
            state_in = S_REP_HEAD;
         end

         // read data belongs to cur_ff, one node per cycle
         S_SRCH: begin
            if (key_hit) begin
               state_in = S_REP_HEAD;
               if (cmd_ff == CMD_INS_AFTER) begin
                  if (free_head_ff == NULL_IDX) begin
                     status_in = ST_FULL;
                  end else begin
                     n_in         = free_head_ff;
                     free_head_in = free_next;
                     after_in     = next_rd_ff;
                     state_in     = S_IA_WR;
                  end
               end else begin
                  // unlink a node that is neither head nor tail
                  if (prev_rd_ff != NULL_IDX) begin
                     next_we    = 1'b1;
                     next_waddr = prev_rd_ff[ADDR_W-1:0];
                     next_wdata = next_rd_ff;
                  end
                  if (next_rd_ff != NULL_IDX) begin
                     prev_we    = 1'b1;
                     prev_waddr = next_rd_ff[ADDR_W-1:0];
                     prev_wdata = prev_rd_ff;
                  end
                  do_release = 1'b1;
                  rel_idx    = cur_ff;
               end
            end else if (next_rd_ff == NULL_IDX) begin
               status_in = ST_NOT_FOUND;
               state_in  = S_REP_HEAD;
            end else begin
               cur_in     = next_rd_ff;
               node_raddr = next_rd_ff[ADDR_W-1:0];
            end
         end

         S_IA_WR: begin
            data_we    = 1'b1;
            next_we    = 1'b1;
            prev_we    = 1'b1;
            next_wdata = after_ff;
            prev_wdata = cur_ff;
            state_in   = S_IA_LINK;
         end

         S_IA_LINK: begin
            next_we    = 1'b1;
            next_waddr = cur_ff[ADDR_W-1:0];
            next_wdata = n_ff;
            if (after_ff != NULL_IDX) begin
               prev_we    = 1'b1;
               prev_waddr = after_ff[ADDR_W-1:0];
               prev_wdata = n_ff;
            end else begin
               tail_in = n_ff;
            end
            count_in = count_ff + 1'b1;
            state_in = S_REP_HEAD;
         end

         // read data belongs to the tail node
         S_TAIL_CHK: begin
            if (cmd_ff == CMD_DEL_END || key_hit) begin
               do_del_end = 1'b1;
               state_in   = S_REP_HEAD;
            end else begin
               cur_in   = head_ff;
               state_in = S_SRCH;
            end
         end

         S_REP_HEAD: begin
            state_in = S_REP_TAIL;
         end

         S_REP_TAIL: begin
            hv_in      = (head_ff != NULL_IDX) ? word_type'(data_rd_ff) : '0;
            node_raddr = tail_ff[ADDR_W-1:0];
            state_in   = S_REP_DONE;
         end

         S_REP_DONE: begin
            node_raddr = tail_ff[ADDR_W-1:0];
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_count_in  = count_field_type'(count_ff);
               rsp_empty_in  = (head_ff == NULL_IDX);
               rsp_head_in   = hv_ff;
               rsp_tail_in   = (tail_ff != NULL_IDX) ? word_type'(data_rd_ff) : '0;
               state_in      = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase

      if (do_del_front) begin
         do_release = 1'b1;
         rel_idx    = head_ff;
         if (head_ff == tail_ff) begin
            head_in = NULL_IDX;
            tail_in = NULL_IDX;
         end else begin
            head_in = next_rd_ff;
            if (next_rd_ff != NULL_IDX) begin
               prev_we    = 1'b1;
               prev_waddr = next_rd_ff[ADDR_W-1:0];
               prev_wdata = NULL_IDX;
            end
         end
      end

      if (do_del_end) begin
         do_release = 1'b1;
         rel_idx    = tail_ff;
         if (tail_ff == head_ff) begin
            head_in = NULL_IDX;
            tail_in = NULL_IDX;
         end else begin
            tail_in = prev_rd_ff;
            if (prev_rd_ff != NULL_IDX) begin
               next_we    = 1'b1;
               next_waddr = prev_rd_ff[ADDR_W-1:0];
               next_wdata = NULL_IDX;
            end
         end
      end

      // released node goes on top of the free chain
      if (do_release) begin
         free_we                           = 1'b1;
         free_waddr                        = rel_idx[ADDR_W-1:0];
         free_head_in                      = rel_idx;
         free_valid_in[rel_idx[ADDR_W-1:0]] = 1'b1;
         if (count_ff != '0) count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         head_ff       <= NULL_IDX;
         tail_ff       <= NULL_IDX;
         count_ff      <= '0;
         free_head_ff  <= '0;
         free_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         free_head_ff  <= free_head_in;
         free_valid_ff <= free_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      value_ff      <= value_in;
      status_ff     <= status_in;
      n_ff          <= n_in;
      cur_ff        <= cur_in;
      after_ff      <= after_in;
      hv_ff         <= hv_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_head_ff   <= rsp_head_in;
      rsp_tail_ff   <= rsp_tail_in;
   end

   always_ff @(posedge clock) begin
      if (data_we) data_mem[data_waddr] <= data_wdata;
      if (next_we) next_mem[next_waddr] <= next_wdata;
      if (prev_we) prev_mem[prev_waddr] <= prev_wdata;
      data_rd_ff <= data_mem[node_raddr];
      next_rd_ff <= next_mem[node_raddr];
      prev_rd_ff <= prev_mem[node_raddr];
   end

   // free chain read always follows the free head
   always_ff @(posedge clock) begin
      if (free_we) free_mem[free_waddr] <= free_head_ff;
      free_rd_ff <= free_mem[free_head_ff[ADDR_W-1:0]];
      free_v_ff  <= free_valid_ff[free_head_ff[ADDR_W-1:0]];
   end

endmodule

>>> rtl/dlle_checker.sv
module dlle_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input dlle_pkg::status_type      rsp_status,
   input dlle_pkg::count_field_type rsp_element_count,
   input logic                      rsp_is_empty,
   input dlle_pkg::word_type        rsp_head_value,
   input dlle_pkg::word_type        rsp_tail_value
);
   import dlle_pkg::*;

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_empty == (rsp_element_count == '0)))
      else $error("empty flag disagrees with element count");

   a_empty_values: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_empty |-> (rsp_head_value == '0) && (rsp_tail_value == '0))
      else $error("empty list reports nonzero head or tail");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FULL) |->
         (rsp_element_count == count_field_type'(CAPACITY)))
      else $error("pool full reported with free nodes left");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_element_count) && $stable(rsp_head_value)
         && $stable(rsp_tail_value))
      else $error("stalled response transaction changed");

endmodule

bind doubly_linked_list_engine dlle_checker u_dlle_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_if.valid),
   .rsp_ready         (rsp_if.ready),
   .rsp_status        (rsp_if.status),
   .rsp_element_count (rsp_if.element_count),
   .rsp_is_empty      (rsp_if.is_empty),
   .rsp_head_value    (rsp_if.head_value),
   .rsp_tail_value    (rsp_if.tail_value)
);

>>> test/doubly_linked_list_engine_test.sv
module doubly_linked_list_engine_test;
   timeunit 1ns;
   timeprecision 1ps;

   import dlle_pkg::*;

   localparam cmd_field_type CMD_UNUSED = 3'd7;
   localparam word_type MAX_WORD = 32'sh7fffffff;
   localparam word_type MIN_WORD = 32'sh80000000;
   localparam int RANDOM_PER_PHASE = 157;

   typedef struct packed {
      status_type      status;
      count_field_type element_count;
      logic            is_empty;
      word_type        head_value;
      word_type        tail_value;
   } list_result_type;

   typedef struct packed {
      cmd_field_type   cmd;
      word_type        key;
      word_type        value;
      bit              typed;
      list_result_type want;
   } stim_row_type;

   localparam list_result_type NO_TYPED = '{ST_OK, '0, 1'b0, '0, '0};

   logic clock = 1'b0;
   logic reset;

   dlle_req_if req_ch ();
   dlle_rsp_if rsp_ch ();

   doubly_linked_list_engine i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch.sink),
      .rsp_if (rsp_ch.source)
   );

   always #2ns clock = ~clock;

   // shadow of the node pool, indexed by the full node index
   data_type     node_mem  [CAPACITY + 1];
   idx_type      next_mem  [CAPACITY + 1];
   idx_type      prev_mem  [CAPACITY + 1];
   idx_type      free_next [CAPACITY + 1];
   idx_type      free_top;
   idx_type      head_ptr;
   idx_type      tail_ptr;
   int           live_count;

   list_result_type result_q [$];
   int           mismatches = 0;
   int           sender_idle_pct = 0;
   int           stall_pct = 0;
   bit           growing = 1'b1;
   int           mode_left = 80;

   stim_row_type directed_rows [25] = '{
      '{CMD_DEL_FRONT, 32'sd0, 32'sd0, 1'b1, '{ST_EMPTY, 6'd0, 1'b1, 32'sd0, 32'sd0}},
      '{CMD_DEL_END,   32'sd0, 32'sd0, 1'b1, '{ST_EMPTY, 6'd0, 1'b1, 32'sd0, 32'sd0}},
      '{CMD_DEL_KEY,   32'sd0, 32'sd0, 1'b1, '{ST_EMPTY, 6'd0, 1'b1, 32'sd0, 32'sd0}},
      '{CMD_INS_AFTER, 32'sd0, 32'sd7, 1'b1, '{ST_EMPTY, 6'd0, 1'b1, 32'sd0, 32'sd0}},
      '{CMD_CLEAR,     32'sd0, 32'sd0, 1'b1, '{ST_OK, 6'd0, 1'b1, 32'sd0, 32'sd0}},
      '{CMD_UNUSED,    MAX_WORD, MIN_WORD, 1'b1, '{ST_OK, 6'd0, 1'b1, 32'sd0, 32'sd0}},
      '{CMD_INS_FRONT, 32'sd0, MAX_WORD, 1'b1, '{ST_OK, 6'd1, 1'b0, MAX_WORD, MAX_WORD}},
      '{CMD_INS_END,   32'sd0, MIN_WORD, 1'b1, '{ST_OK, 6'd2, 1'b0, MAX_WORD, MIN_WORD}},
      '{CMD_INS_AFTER, 32'sd5, 32'sd9, 1'b1, '{ST_NOT_FOUND, 6'd2, 1'b0, MAX_WORD, MIN_WORD}},
      '{CMD_INS_AFTER, MAX_WORD, 32'sd0, 1'b0, NO_TYPED},
      '{CMD_INS_END,   32'sd0, -32'sd1, 1'b0, NO_TYPED},
      '{CMD_INS_FRONT, 32'sd0, 32'sd1, 1'b0, NO_TYPED},
      '{CMD_INS_AFTER, MIN_WORD, 32'sh5555, 1'b0, NO_TYPED},
      '{CMD_UNUSED,    32'sh5a5a5a5a, 32'sha5a5a5a5, 1'b0, NO_TYPED},
      '{CMD_DEL_KEY,   32'sd1, 32'sd0, 1'b0, NO_TYPED},
      '{CMD_DEL_KEY,   -32'sd1, 32'sd0, 1'b0, NO_TYPED},
      '{CMD_DEL_KEY,   32'sd0, 32'sd0, 1'b0, NO_TYPED},
      '{CMD_DEL_KEY,   32'sd12345, 32'sd0, 1'b0, NO_TYPED},
      '{CMD_DEL_FRONT, 32'sd0, 32'sd0, 1'b0, NO_TYPED},
      '{CMD_DEL_END,   32'sd0, 32'sd0, 1'b0, NO_TYPED},
      '{CMD_INS_END,   32'sd0, 32'shaaaaaaaa, 1'b0, NO_TYPED},
      '{CMD_INS_END,   32'sd0, 32'shaaaaaaaa, 1'b0, NO_TYPED},
      '{CMD_DEL_KEY,   32'shaaaaaaaa, 32'sd0, 1'b0, NO_TYPED},
      '{CMD_CLEAR,     32'sd0, 32'sd0, 1'b1, '{ST_OK, 6'd0, 1'b1, 32'sd0, 32'sd0}},
      '{CMD_DEL_END,   32'sd0, 32'sd0, 1'b1, '{ST_EMPTY, 6'd0, 1'b1, 32'sd0, 32'sd0}}
   };

   function automatic void clear_list();
      for (int i = 0; i < CAPACITY; i++)
         free_next[i] = idx_type'(i + 1);
      free_top   = '0;
      head_ptr   = NULL_IDX;
      tail_ptr   = NULL_IDX;
      live_count = 0;
   endfunction

   function automatic idx_type take_node(input data_type d);
      idx_type n;
      n = free_top;
      if (n == NULL_IDX)
         return NULL_IDX;
      free_top    = free_next[n];
      node_mem[n] = d;
      next_mem[n] = NULL_IDX;
      prev_mem[n] = NULL_IDX;
      return n;
   endfunction

   function automatic void give_back(input idx_type n);
      free_next[n] = free_top;
      free_top     = n;
      if (live_count > 0)
         live_count--;
   endfunction

   function automatic idx_type find_node(input data_type k);
      idx_type cur;
      int      steps;
      cur   = head_ptr;
      steps = 0;
      while (cur != NULL_IDX && steps < CAPACITY) begin
         if (node_mem[cur] == k)
            return cur;
         cur = next_mem[cur];
         steps++;
      end
      return NULL_IDX;
   endfunction

   function automatic status_type drop_front();
      idx_type old;
      old = head_ptr;
      if (old == NULL_IDX)
         return ST_EMPTY;
      if (old == tail_ptr) begin
         head_ptr = NULL_IDX;
         tail_ptr = NULL_IDX;
      end else begin
         head_ptr = next_mem[old];
         if (head_ptr != NULL_IDX)
            prev_mem[head_ptr] = NULL_IDX;
      end
      give_back(old);
      return ST_OK;
   endfunction

   function automatic status_type drop_back();
      idx_type old;
      old = tail_ptr;
      if (old == NULL_IDX)
         return ST_EMPTY;
      if (old == head_ptr) begin
         head_ptr = NULL_IDX;
         tail_ptr = NULL_IDX;
      end else begin
         tail_ptr = prev_mem[old];
         if (tail_ptr != NULL_IDX)
            next_mem[tail_ptr] = NULL_IDX;
      end
      give_back(old);
      return ST_OK;
   endfunction

   function automatic void link_new(input idx_type n, input bit at_front);
      if (head_ptr == NULL_IDX) begin
         head_ptr = n;
         tail_ptr = n;
      end else if (at_front) begin
         next_mem[n]        = head_ptr;
         prev_mem[head_ptr] = n;
         head_ptr           = n;
      end else begin
         prev_mem[n]        = tail_ptr;
         next_mem[tail_ptr] = n;
         tail_ptr           = n;
      end
      live_count++;
   endfunction

   function automatic list_result_type predict_list_op(input cmd_field_type c,
                                                      input word_type k_in,
                                                      input word_type v_in);
      list_result_type r;
      data_type     k;
      data_type     d;
      idx_type      n;
      idx_type      at;
      idx_type      after;
      idx_type      p;
      idx_type      q;
      status_type   st;
      k  = data_type'(k_in);
      d  = data_type'(v_in);
      st = ST_OK;
      case (c)
         CMD_INS_FRONT, CMD_INS_END: begin
            n = take_node(d);
            if (n == NULL_IDX)
               st = ST_FULL;
            else
               link_new(n, c == CMD_INS_FRONT);
         end
         CMD_INS_AFTER: begin
            if (head_ptr == NULL_IDX) begin
               st = ST_EMPTY;
            end else begin
               at = find_node(k);
               if (at == NULL_IDX) begin
                  st = ST_NOT_FOUND;
               end else begin
                  n = take_node(d);
                  if (n == NULL_IDX) begin
                     st = ST_FULL;
                  end else begin
                     after       = next_mem[at];
                     next_mem[n] = after;
                     prev_mem[n] = at;
                     if (after != NULL_IDX)
                        prev_mem[after] = n;
                     else
                        tail_ptr = n;
                     next_mem[at] = n;
                     live_count++;
                  end
               end
            end
         end
         CMD_DEL_FRONT: st = drop_front();
         CMD_DEL_END:   st = drop_back();
         CMD_DEL_KEY: begin
            // head first, then tail, then a walk from the head
            if (head_ptr == NULL_IDX || tail_ptr == NULL_IDX) begin
               st = ST_EMPTY;
            end else if (node_mem[head_ptr] == k) begin
               st = drop_front();
            end else if (node_mem[tail_ptr] == k) begin
               st = drop_back();
            end else begin
               n = find_node(k);
               if (n == NULL_IDX) begin
                  st = ST_NOT_FOUND;
               end else begin
                  p = prev_mem[n];
                  q = next_mem[n];
                  if (p != NULL_IDX)
                     next_mem[p] = q;
                  if (q != NULL_IDX)
                     prev_mem[q] = p;
                  give_back(n);
               end
            end
         end
         CMD_CLEAR: clear_list();
         default: ;
      endcase
      r.status        = st;
      r.element_count = count_field_type'(live_count);
      r.is_empty      = (head_ptr == NULL_IDX);
      r.head_value    = (head_ptr == NULL_IDX) ? '0 : word_type'(node_mem[head_ptr]);
      r.tail_value    = (tail_ptr == NULL_IDX) ? '0 : word_type'(node_mem[tail_ptr]);
      return r;
   endfunction

   function automatic word_type pick_value();
      if ($urandom_range(0, 99) < 60)
         return word_type'(int'($urandom_range(0, 15)) - 8);
      return word_type'($urandom);
   endfunction

   // mostly keys that sit somewhere in the current list
   function automatic word_type pick_key();
      idx_type cur;
      int      steps;
      int      roll;
      roll = $urandom_range(0, 99);
      if (roll < 65 && head_ptr != NULL_IDX) begin
         cur   = head_ptr;
         steps = $urandom_range(0, live_count - 1);
         while (steps > 0 && next_mem[cur] != NULL_IDX) begin
            cur = next_mem[cur];
            steps--;
         end
         return word_type'(node_mem[cur]);
      end
      if (roll < 80)
         return word_type'(int'($urandom_range(0, 15)) - 8);
      return word_type'($urandom);
   endfunction

   function automatic cmd_field_type pick_cmd();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll == 0)
         return CMD_CLEAR;
      if (roll == 1)
         return CMD_UNUSED;
      if (growing) begin
         if (roll < 32) return CMD_INS_FRONT;
         if (roll < 62) return CMD_INS_END;
         if (roll < 92) return CMD_INS_AFTER;
         if (roll < 95) return CMD_DEL_FRONT;
         if (roll < 97) return CMD_DEL_END;
         return CMD_DEL_KEY;
      end
      if (roll < 8)  return CMD_INS_FRONT;
      if (roll < 16) return CMD_INS_END;
      if (roll < 24) return CMD_INS_AFTER;
      if (roll < 46) return CMD_DEL_FRONT;
      if (roll < 68) return CMD_DEL_END;
      return CMD_DEL_KEY;
   endfunction

   task automatic log_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch at %0t: %s", $time, msg);
   endtask

   // entered just after a falling edge, returns just after a falling edge
   task automatic send_txn(input cmd_field_type c, input word_type k, input word_type v,
                           input bit typed, input list_result_type want);
      list_result_type predicted;
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.cmd   <= c;
      req_ch.key   <= k;
      req_ch.value <= v;
      do
         @(posedge clock);
      while (!req_ch.ready);
      predicted = predict_list_op(c, k, v);
      result_q.push_back(typed ? want : predicted);
      @(negedge clock);
   endtask

   task automatic send_random(input int count);
      cmd_field_type c;
      word_type      k;
      word_type      v;
      for (int i = 0; i < count; i++) begin
         if (mode_left == 0) begin
            growing   = !growing;
            mode_left = $urandom_range(40, 90);
         end
         mode_left--;
         c = pick_cmd();
         k = pick_key();
         v = pick_value();
         send_txn(c, k, v, 1'b0, NO_TYPED);
      end
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      do
         @(negedge clock);
      while (result_q.size() != 0);
   endtask

   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      list_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (result_q.size() == 0) begin
            log_mismatch($sformatf("result with nothing pending: status %0d count %0d",
                                   rsp_ch.status, rsp_ch.element_count));
         end else begin
            want = result_q.pop_front();
            if (rsp_ch.status !== want.status)
               log_mismatch($sformatf("status expected %0d, got %0d",
                                      want.status, rsp_ch.status));
            if (rsp_ch.element_count !== want.element_count)
               log_mismatch($sformatf("element_count expected %0d, got %0d",
                                      want.element_count, rsp_ch.element_count));
            if (rsp_ch.is_empty !== want.is_empty)
               log_mismatch($sformatf("is_empty expected %0d, got %0d",
                                      want.is_empty, rsp_ch.is_empty));
            if (rsp_ch.head_value !== want.head_value)
               log_mismatch($sformatf("head_value expected %0d, got %0d",
                                      want.head_value, rsp_ch.head_value));
            if (rsp_ch.tail_value !== want.tail_value)
               log_mismatch($sformatf("tail_value expected %0d, got %0d",
                                      want.tail_value, rsp_ch.tail_value));
         end
      end
   end

   initial begin
      #2ms;
      $display("doubly_linked_list_engine regression: fail");
      $finish;
   end

   initial begin
      reset        = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.cmd   = CMD_INS_FRONT;
      req_ch.key   = '0;
      req_ch.value = '0;
      clear_list();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_txn(directed_rows[i].cmd, directed_rows[i].key, directed_rows[i].value,
                  directed_rows[i].typed, directed_rows[i].want);
      // first random stretch fills the pool
      growing   = 1'b1;
      mode_left = 80;
      send_random(RANDOM_PER_PHASE);
      drain_results();

      sender_idle_pct = 80;
      send_random(RANDOM_PER_PHASE);
      drain_results();

      sender_idle_pct = 0;
      stall_pct       = 80;
      send_random(RANDOM_PER_PHASE);
      drain_results();

      sender_idle_pct = 37;
      stall_pct       = 37;
      send_random(RANDOM_PER_PHASE);
      drain_results();

      stall_pct = 0;
      repeat (60) @(posedge clock);
      if (mismatches == 0 && result_q.size() == 0) begin
         $display("doubly_linked_list_engine regression: pass");
      end else begin
         $display("doubly_linked_list_engine regression: fail");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/dlle_pkg.sv
rtl/dlle_if.sv
rtl/doubly_linked_list_engine.sv
rtl/dlle_checker.sv
test/doubly_linked_list_engine_test.sv
